[hdl/saturation_flag_disk_dilation_assert.svh]
// Assertion macros used by the block's top module.
`ifndef SATURATION_FLAG_DISK_DILATION_ASSERT_SVH
`define SATURATION_FLAG_DISK_DILATION_ASSERT_SVH

// An implication that must hold at every clock edge outside reset.
`define SFDD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define SFDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sfdd_pkg.sv]
package sfdd_pkg;

  localparam int DEF_MAX_COLS = 512;
  localparam int DEF_MAX_ROWS = 512;

  localparam int CNT_W = 19;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_RUN   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_COLS   = 3'd0,
    CFG_ROWS   = 3'd1,
    CFG_THRESH = 3'd2,
    CFG_RADIUS = 3'd3,
    CFG_FLAGS  = 3'd4,
    CFG_ENABLE = 3'd5
  } cfg_idx_t;

  // Control bundle for a sequencer and mask write-back path; no module in the block uses it.
  typedef struct packed {
    logic rd_pend;
    logic rmw_pend;
  } seq_ctl_t;

endpackage

[hdl/sfdd_ram.sv]
module sfdd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/sfdd_disk.sv]
// Disk membership test for one offset: 256*(dx^2+dy^2) <= r^2.
module sfdd_disk
  import sfdd_pkg::*;
#(
  parameter int OFS_W = 5
) (
  input  logic             clk,
  input  logic [OFS_W-1:0] adx,
  input  logic [OFS_W-1:0] ady,
  input  logic [7:0]       radius_q4,
  output logic             inside_r
);

  logic [2*OFS_W:0] sq;
  logic [15:0]      lim;

  assign sq  = (2*OFS_W+1)'(adx * adx) + (2*OFS_W+1)'(ady * ady);
  assign lim = 16'(radius_q4 * radius_q4);

  always_ff @(posedge clk) begin
    inside_r <= ({sq, 8'd0} <= (2*OFS_W+9)'(lim));
  end

endmodule

[hdl/saturation_flag_disk_dilation.sv]
// Saturation flagging with disk dilation.
// Configuration: write cfg_we with cfg_index and cfg_wdata; the register
// takes the value at that edge. Write only while the block is idle.
// Commands: raise start while busy is low; the command beat is taken at that
// edge. Op 0 writes a pixel and its mask word, op 1 reads a mask word, op 2
// runs the flagging pass, op 3 does nothing. Each command produces exactly
// one result beat on out_valid.
// Writes and unused ops show their result in the cycle right after the
// accepting edge; reads first pass through S_RD, where the mask memory's
// registered read returns, and show it in the cycle after that. busy stays
// high through the result cycle, so no new command is taken until it ends.
// If enabled and the image in use is not empty, a run walks it pixel by
// pixel (read pixel, compare), and for each pixel above threshold walks the
// clipped box around it cell by cell (read mask, test disk, OR in flags,
// write back if inside the disk). The clipped box holds at most (2h+1)^2
// cells, with h the radius rounded to whole pixels; each cell is read and
// written back through the single mask memory port pair.
// The receiver cannot stall: out_valid is high for one cycle only.
// Reset clears the control state and loads the register reset values;
// the image memories are left undefined until written.
module saturation_flag_disk_dilation
  import sfdd_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   in_op,
  input  logic [8:0]   in_col,
  input  logic [8:0]   in_row,
  input  logic [31:0]  in_pixel_value,
  input  logic [15:0]  in_mask_value,
  output logic         out_valid,
  output logic [15:0]  out_mask_out,
  output logic [18:0]  out_flagged_count,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);
`include "saturation_flag_disk_dilation_assert.svh"

  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AW    = CW + RW;
  localparam int DEPTH = 1 << AW;
  localparam int SW    = 13;  // signed coordinates with margin

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DONE = 7'b0000010,
    S_RD   = 7'b0000100,
    S_SCAN = 7'b0001000,
    S_SCMP = 7'b0010000,
    S_BOX  = 7'b0100000,
    S_BWR  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [9:0]  cols_r, rows_r;
  logic [31:0] thresh_r;
  logic [7:0]  radius_r;
  logic [15:0] flags_r;
  logic        enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r   <= 10'd512;
      rows_r   <= 10'd512;
      thresh_r <= 32'h7FFF_FFFF;
      radius_r <= 8'd16;
      flags_r  <= 16'd256;
      enable_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS:   cols_r   <= cfg_wdata[9:0];
        CFG_ROWS:   rows_r   <= cfg_wdata[9:0];
        CFG_THRESH: thresh_r <= cfg_wdata;
        CFG_RADIUS: radius_r <= cfg_wdata[7:0];
        CFG_FLAGS:  flags_r  <= cfg_wdata[15:0];
        CFG_ENABLE: enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamped image size.
  logic [SW-1:0] nc, nr;
  assign nc = (32'(cols_r) > MAX_COLS) ? SW'(MAX_COLS) : SW'(cols_r);
  assign nr = (32'(rows_r) > MAX_ROWS) ? SW'(MAX_ROWS) : SW'(rows_r);
  logic [4:0] half;
  assign half = 5'((9'(radius_r) + 9'd8) >> 4);

  // Scan and box cursors.
  logic [SW-1:0] sc_r, sr_r, sc_nxt, sr_nxt;
  logic [SW-1:0] bc_r, br_r, bc_nxt, br_nxt;
  logic [SW-1:0] clo_r, chi_r, rhi_r, clo_nxt, chi_nxt, rhi_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0] mout_r, mout_nxt;
  logic        op_rd_r, op_rd_nxt;

  // Memory ports.
  logic          pix_we, msk_we;
  logic [AW-1:0] pix_waddr, pix_raddr, msk_waddr, msk_raddr;
  logic [31:0]   pix_wdata, pix_rdata;
  logic [15:0]   msk_wdata, msk_rdata;

  function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] r, input logic [SW-1:0] c);
    addr_of = {r[RW-1:0], c[CW-1:0]};
  endfunction

  sfdd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_pix (
    .clk, .we(pix_we), .waddr(pix_waddr), .wdata(pix_wdata),
    .raddr(pix_raddr), .rdata(pix_rdata)
  );
  sfdd_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_msk (
    .clk, .we(msk_we), .waddr(msk_waddr), .wdata(msk_wdata),
    .raddr(msk_raddr), .rdata(msk_rdata)
  );

  // Disk test on the absolute box offset, registered alongside the read.
  logic [SW-1:0] dx, dy;
  logic [4:0]    adx, ady;
  logic          inside_r;
  assign dx  = bc_r - sc_r;
  assign dy  = br_r - sr_r;
  assign adx = dx[SW-1] ? 5'(-dx) : 5'(dx);
  assign ady = dy[SW-1] ? 5'(-dy) : 5'(dy);

  sfdd_disk #(.OFS_W(5)) u_disk (
    .clk, .adx(adx), .ady(ady), .radius_q4(radius_r), .inside_r(inside_r)
  );

  logic in_store;
  assign in_store = (32'(in_col) < MAX_COLS) && (32'(in_row) < MAX_ROWS);

  logic hit;
  assign hit = $signed(pix_rdata) > $signed(thresh_r);

  always_comb begin
    logic [SW-1:0] lo, hi;
    state_nxt = state_r;
    sc_nxt = sc_r; sr_nxt = sr_r; bc_nxt = bc_r; br_nxt = br_r;
    clo_nxt = clo_r; chi_nxt = chi_r; rhi_nxt = rhi_r;
    cnt_nxt = cnt_r; mout_nxt = mout_r; op_rd_nxt = op_rd_r;
    pix_we = 1'b0; msk_we = 1'b0;
    pix_waddr = addr_of(SW'(in_row), SW'(in_col));
    pix_wdata = in_pixel_value;
    msk_waddr = addr_of(br_r, bc_r);
    msk_wdata = msk_rdata | flags_r;
    pix_raddr = addr_of(sr_r, sc_r);
    msk_raddr = addr_of(br_r, bc_r);
    lo = '0; hi = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          mout_nxt = '0; cnt_nxt = '0; op_rd_nxt = 1'b0;
          msk_raddr = addr_of(SW'(in_row), SW'(in_col));
          case (in_op)
            OP_WRITE: begin
              pix_we = in_store; msk_we = in_store;
              msk_waddr = addr_of(SW'(in_row), SW'(in_col));
              msk_wdata = in_mask_value;
              state_nxt = S_DONE;
            end
            OP_READ: begin
              op_rd_nxt = in_store;
              state_nxt = S_RD;
            end
            OP_RUN: begin
              sc_nxt = '0; sr_nxt = '0;
              if (enable_r && nc != '0 && nr != '0) state_nxt = S_SCAN;
              else state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_RD: begin
        mout_nxt = op_rd_r ? msk_rdata : 16'd0;
        state_nxt = S_DONE;
      end
      S_SCAN: state_nxt = S_SCMP;  // pixel read in flight
      S_SCMP: begin
        if (hit) begin
          if (cnt_r != COUNT_MAX) cnt_nxt = cnt_r + 1'b1;
          lo = sc_r - SW'(half);
          clo_nxt = lo[SW-1] ? '0 : lo;
          hi = sc_r + SW'(half);
          chi_nxt = (hi > nc - 1'b1) ? nc - 1'b1 : hi;
          lo = sr_r - SW'(half);
          br_nxt = lo[SW-1] ? '0 : lo;
          hi = sr_r + SW'(half);
          rhi_nxt = (hi > nr - 1'b1) ? nr - 1'b1 : hi;
          bc_nxt = clo_nxt;
          state_nxt = S_BOX;
        end else if (sc_r == nc - 1'b1) begin
          sc_nxt = '0;
          if (sr_r == nr - 1'b1) state_nxt = S_DONE;
          else begin sr_nxt = sr_r + 1'b1; state_nxt = S_SCAN; end
        end else begin
          sc_nxt = sc_r + 1'b1; state_nxt = S_SCAN;
        end
      end
      S_BOX: state_nxt = S_BWR;  // mask read and disk test in flight
      S_BWR: begin
        msk_we = inside_r;
        if (bc_r == chi_r) begin
          bc_nxt = clo_r;
          if (br_r == rhi_r) begin
            if (sc_r == nc - 1'b1) begin
              sc_nxt = '0;
              if (sr_r == nr - 1'b1) state_nxt = S_DONE;
              else begin sr_nxt = sr_r + 1'b1; state_nxt = S_SCAN; end
            end else begin
              sc_nxt = sc_r + 1'b1; state_nxt = S_SCAN;
            end
          end else begin
            br_nxt = br_r + 1'b1; state_nxt = S_BOX;
          end
        end else begin
          bc_nxt = bc_r + 1'b1; state_nxt = S_BOX;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    sc_r <= sc_nxt; sr_r <= sr_nxt; bc_r <= bc_nxt; br_r <= br_nxt;
    clo_r <= clo_nxt; chi_r <= chi_nxt; rhi_r <= rhi_nxt;
    cnt_r <= cnt_nxt; mout_r <= mout_nxt; op_rd_r <= op_rd_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = (state_r == S_DONE);
  assign out_mask_out      = mout_r;
  assign out_flagged_count = cnt_r;

  `SFDD_ASSERT_NEXT(a_done_one_beat, clk, rst_n, out_valid, !out_valid,
    "result beat lasted more than one cycle")
  `SFDD_ASSERT_IMP(a_no_mask_write_in_scan, clk, rst_n,
    state_r == S_SCAN || state_r == S_SCMP, !msk_we, "mask write during scan")
  `SFDD_ASSERT_IMP(a_box_in_image, clk, rst_n, state_r == S_BWR,
    bc_r < nc && br_r < nr, "box cell outside image")
  `SFDD_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy,
    "accepted command did not raise busy")

endmodule

[verif/saturation_flag_disk_dilation_tb.sv]
module saturation_flag_disk_dilation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfdd_pkg::*;

  localparam int STORE_COLS = DEF_MAX_COLS;
  localparam int STORE_ROWS = DEF_MAX_ROWS;
  localparam int STORE_SIZE = STORE_COLS * STORE_ROWS;
  localparam int BEATS_PER_PHASE = 30;

  // Register indexes past the last real register; writes there must do nothing.
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [8:0]  in_col;
  logic [8:0]  in_row;
  logic [31:0] in_pixel_value;
  logic [15:0] in_mask_value;
  logic        out_valid;
  logic [15:0] out_mask_out;
  logic [18:0] out_flagged_count;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  saturation_flag_disk_dilation u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_col            (in_col),
    .in_row            (in_row),
    .in_pixel_value    (in_pixel_value),
    .in_mask_value     (in_mask_value),
    .out_valid         (out_valid),
    .out_mask_out      (out_mask_out),
    .out_flagged_count (out_flagged_count),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // One expected result beat.
  typedef struct {
    logic [15:0] mask_word;
    logic [18:0] hit_count;
  } flag_result_t;

  // Shadow copy of the image, the quality mask and the register file.
  logic signed [31:0] pixel_img [0:STORE_SIZE-1];
  logic [15:0]        mask_img  [0:STORE_SIZE-1];
  bit                 pixel_set [0:STORE_SIZE-1];
  int                 set_addrs [$];

  logic [9:0]         sh_cols;
  logic [9:0]         sh_rows;
  logic signed [31:0] sh_thresh;
  logic [7:0]         sh_radius;
  logic [15:0]        sh_flags;
  logic               sh_enable;

  flag_result_t pending_results [$];
  int           error_count;
  int           beats_sent;
  int           idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; the slowest correct run is far shorter.
  initial begin
    #100ms;
    $display("Simulation FAILED");
    $finish;
  end

  // ORs the flag bits into every in-image pixel within the disk around (c0, r0).
  function automatic void dilate_disk(int c0, int r0, int nc, int nr);
    int half, lim, clo, chi, rlo, rhi, dx, dy, a;
    half = (int'(sh_radius) + 8) >> 4;
    lim  = int'(sh_radius) * int'(sh_radius);
    clo  = (c0 - half < 0) ? 0 : c0 - half;
    rlo  = (r0 - half < 0) ? 0 : r0 - half;
    chi  = (c0 + half > nc - 1) ? nc - 1 : c0 + half;
    rhi  = (r0 + half > nr - 1) ? nr - 1 : r0 + half;
    for (int r = rlo; r <= rhi; r++) begin
      dy = r - r0;
      for (int c = clo; c <= chi; c++) begin
        dx = c - c0;
        if (256 * (dx * dx + dy * dy) <= lim) begin
          a = r * STORE_COLS + c;
          mask_img[a] = mask_img[a] | sh_flags;
        end
      end
    end
  endfunction

  // Whole flagging pass: counts pixels above threshold and grows the mask.
  function automatic logic [18:0] flag_pass();
    int nc, nr, a;
    logic [18:0] hits;
    nc   = (sh_cols > STORE_COLS) ? STORE_COLS : int'(sh_cols);
    nr   = (sh_rows > STORE_ROWS) ? STORE_ROWS : int'(sh_rows);
    hits = '0;
    if (!sh_enable) return '0;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        a = r * STORE_COLS + c;
        if (pixel_img[a] > sh_thresh) begin
          dilate_disk(c, r, nc, nr);
          if (hits != COUNT_MAX) hits++;
        end
      end
    end
    return hits;
  endfunction

  function automatic flag_result_t predict_command(op_t op, int col, int row,
                                                   logic [31:0] pix,
                                                   logic [15:0] msk);
    flag_result_t res;
    int a;
    a = row * STORE_COLS + col;
    res.mask_word = '0;
    res.hit_count = '0;
    case (op)
      OP_WRITE: begin
        pixel_img[a] = pix;
        mask_img[a]  = msk;
        if (!pixel_set[a]) set_addrs.push_back(a);
        pixel_set[a] = 1'b1;
      end
      OP_READ: res.mask_word = mask_img[a];
      OP_RUN:  res.hit_count = flag_pass();
      default: ;
    endcase
    return res;
  endfunction

  // Sends one command beat, with random idle cycles before it, and records
  // the expected result at the edge where the block takes it.
  task automatic send_cmd(op_t op, int col, int row, logic [31:0] pix,
                          logic [15:0] msk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_op          <= op;
    in_col         <= col[8:0];
    in_row         <= row[8:0];
    in_pixel_value <= pix;
    in_mask_value  <= msk;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_results.push_back(predict_command(op, col, row, pix, msk));
    beats_sent++;
  endtask

  // Lets every outstanding result arrive, plus a short settle time.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_cfg(logic [2:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_COLS:   sh_cols   = data[9:0];
      CFG_ROWS:   sh_rows   = data[9:0];
      CFG_THRESH: sh_thresh = data;
      CFG_RADIUS: sh_radius = data[7:0];
      CFG_FLAGS:  sh_flags  = data[15:0];
      CFG_ENABLE: sh_enable = data[0];
      default: ;
    endcase
  endtask

  task automatic set_image(int cols, int rows, logic [31:0] thresh, int radius,
                           logic [15:0] flags, logic enable);
    set_cfg(CFG_COLS, cols);
    set_cfg(CFG_ROWS, rows);
    set_cfg(CFG_THRESH, thresh);
    set_cfg(CFG_RADIUS, radius);
    set_cfg(CFG_FLAGS, {16'd0, flags});
    set_cfg(CFG_ENABLE, {31'd0, enable});
  endtask

  // Pixel values cluster around the threshold so the strict compare is hit
  // exactly, just above and just below; the rest are wild.
  function automatic logic [31:0] pick_pixel();
    case ($urandom_range(3))
      0: return $urandom;
      1: return sh_thresh + $signed($urandom_range(4)) - 2;
      2: return sh_thresh;
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  // Writes every pixel of an nc x nr corner so a run never reads stale memory.
  task automatic fill_image(int nc, int nr);
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        send_cmd(OP_WRITE, c, r, pick_pixel(), 16'($urandom));
  endtask

  task automatic read_written(int n);
    int a;
    for (int i = 0; i < n; i++) begin
      a = set_addrs[$urandom_range(set_addrs.size() - 1)];
      send_cmd(OP_READ, a % STORE_COLS, a / STORE_COLS, $urandom, 16'($urandom));
    end
  endtask

  // Result checker: every beat must match the oldest expectation.
  always @(posedge clk) begin
    flag_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: mask %h count %0d", $time,
                 out_mask_out, out_flagged_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_mask_out !== want.mask_word) begin
          $display("%0t: mask_out expected %h actual %h", $time,
                   want.mask_word, out_mask_out);
          error_count++;
        end
        if (out_flagged_count !== want.hit_count) begin
          $display("%0t: flagged_count expected %0d actual %0d", $time,
                   want.hit_count, out_flagged_count);
          error_count++;
        end
      end
    end
  end

  // Small image with extreme pixel and mask values, a read, the unused op,
  // a run and the reads that show the dilated mask.
  task automatic test_basic_ops();
    logic [31:0] corner_vals [12];
    corner_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF,
                    32'h0000_0100, 32'h0, 32'h0, 32'h0, 32'h8000_0001, 32'h0, 32'h2};
    set_image(4, 3, 32'h0, 16, 16'h0100, 1'b1);
    for (int i = 0; i < 12; i++)
      send_cmd(OP_WRITE, i % 4, i / 4, corner_vals[i], (i % 2) ? 16'hFFFF : 16'h0000);
    send_cmd(OP_READ, 1, 0, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(OP_NONE, 511, 511, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(OP_RUN, 0, 0, 32'h0, 16'h0);
    send_cmd(OP_READ, 0, 0, 32'h0, 16'h0);
    send_cmd(OP_READ, 2, 1, 32'h0, 16'h0);
    send_cmd(OP_READ, 3, 2, 32'h0, 16'h0);
    drain();
  endtask

  // Register extremes: empty and saturated sizes, both threshold limits,
  // zero and full radius, flagging off, and writes to spare indexes.
  task automatic test_register_extremes();
    // An empty width gives an empty image even with the height saturated.
    set_image(0, 1023, 32'h8000_0000, 16, 16'h0001, 1'b1);
    send_cmd(OP_RUN, 0, 0, 32'h0, 16'h0);
    drain();

    // Width above the store saturates: the run walks the whole first row.
    set_image(1023, 1, 32'h0, 16, 16'h0002, 1'b1);
    fill_image(STORE_COLS, 1);
    send_cmd(OP_RUN, 0, 0, 32'h0, 16'h0);
    read_written(3);
    drain();

    set_image(3, 3, 32'h7FFF_FFFF, 0, 16'hFFFF, 1'b1);
    fill_image(3, 3);
    send_cmd(OP_RUN, 0, 0, 32'h0, 16'h0);
    drain();
    set_cfg(CFG_THRESH, 32'h8000_0000);
    send_cmd(OP_RUN, 0, 0, 32'h0, 16'h0);
    read_written(2);
    drain();
    set_cfg(CFG_RADIUS, 255);
    set_cfg(CFG_FLAGS, 32'h0000_8000);
    send_cmd(OP_RUN, 0, 0, 32'h0, 16'h0);
    read_written(2);
    drain();
    set_cfg(CFG_ENABLE, 32'h0);
    send_cmd(OP_RUN, 0, 0, 32'h0, 16'h0);
    drain();
    set_cfg(CFG_SPARE_LO, 32'hFFFF_FFFF);
    set_cfg(CFG_SPARE_HI, 32'h0000_0001);
    send_cmd(OP_RUN, 0, 0, 32'h0, 16'h0);
    drain();
  endtask

  // Random sequences: fresh registers, a fully written small image mixed with
  // stray writes, reads and unused ops, then a run and reads of the result.
  task automatic test_random_runs(int pct);
    int target, nc, nr, radius;
    logic [31:0] thresh;
    idle_pct = pct;
    target   = beats_sent + BEATS_PER_PHASE;
    while (beats_sent < target) begin
      nc     = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      nr     = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(8, 1);
      radius = $urandom_range(3) ? $urandom_range(48) : $urandom_range(255);
      thresh = $urandom_range(1) ? $urandom : $urandom_range(2000) - 1000;
      drain();
      set_image(nc, nr, thresh, radius, 16'($urandom), $urandom_range(9) != 0);
      fill_image(nc, nr);
      for (int i = $urandom_range(4); i > 0; i--) begin
        case ($urandom_range(2))
          0: send_cmd(OP_WRITE, $urandom_range(511), $urandom_range(511), $urandom,
                      16'($urandom));
          1: read_written(1);
          default: send_cmd(OP_NONE, $urandom_range(511), $urandom_range(511),
                            $urandom, 16'($urandom));
        endcase
      end
      send_cmd(OP_RUN, $urandom_range(511), $urandom_range(511), $urandom,
               16'($urandom));
      read_written($urandom_range(6, 1));
    end
    drain();
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_op          = OP_NONE;
    in_col         = '0;
    in_row         = '0;
    in_pixel_value = '0;
    in_mask_value  = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_COLS;
    cfg_wdata      = '0;
    error_count    = 0;
    beats_sent     = 0;
    idle_pct       = 0;
    sh_cols        = 10'd512;
    sh_rows        = 10'd512;
    sh_thresh      = 32'h7FFF_FFFF;
    sh_radius      = 8'd16;
    sh_flags       = 16'h0100;
    sh_enable      = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_register_extremes();
    test_random_runs(0);
    test_random_runs(52);
    test_random_runs(12);

    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
